FILE: rtl/core/wccr_pkg.sv
// ----------------------------------------------------------------------------
// wccr_pkg
// Shared types, widths and constants of the cancel ratio detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wccr_pkg;

  localparam int USER_IDX_W = 4;
  localparam int TIME_W     = 48;
  localparam int CNT_OUT_W  = 6;
  localparam int WINDOW_W   = 20;
  localparam int MINEV_W    = 6;
  localparam int RATIO_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int USERS_DEF = 16;
  localparam int DEPTH_DEF = 32;

  localparam int PCT_FULL = 100;

  localparam logic [WINDOW_W-1:0] WINDOW_RST = WINDOW_W'(5000);
  localparam logic [MINEV_W-1:0]  MINEV_RST  = MINEV_W'(3);
  localparam logic [RATIO_W-1:0]  RATIO_RST  = RATIO_W'(70);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW     = 2'd0,
    CFG_MIN_EVENTS = 2'd1,
    CFG_RATIO      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [WINDOW_W-1:0] window_ms;
    logic [MINEV_W-1:0]  min_events;
    logic [RATIO_W-1:0]  ratio_percent;
  } cfg_t;

  typedef struct packed {
    logic              is_cancel;
    logic [TIME_W-1:0] event_time;
  } evt_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STATE,
    S_FULL,
    S_CHECK,
    S_DONE
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/wccr_in_if.sv
// ----------------------------------------------------------------------------
// wccr_in_if
// Event channel: user index, cancel flag and timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface wccr_in_if;
  import wccr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [USER_IDX_W-1:0] user_index;
  logic                  is_cancel;
  logic [TIME_W-1:0]     event_time;

  modport source (output valid, output user_index, output is_cancel,
                  output event_time, input ready);
  modport sink   (input valid, input user_index, input is_cancel,
                  input event_time, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/wccr_out_if.sv
// ----------------------------------------------------------------------------
// wccr_out_if
// Result channel: alert, window counts and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface wccr_out_if;
  import wccr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 alert;
  logic [CNT_OUT_W-1:0] window_cancels;
  logic [CNT_OUT_W-1:0] total_count;
  logic                 overflowed;

  modport source (output valid, output alert, output window_cancels,
                  output total_count, output overflowed, input ready);
  modport sink   (input valid, input alert, input window_cancels,
                  input total_count, input overflowed, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/wccr_cfg_if.sv
// ----------------------------------------------------------------------------
// wccr_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface wccr_cfg_if;
  import wccr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/windowed_cancel_ratio_detector_unit.sv
// ----------------------------------------------------------------------------
// windowed_cancel_ratio_detector_unit
// Per-user sliding window of order events with cancel ratio alert.
// ----------------------------------------------------------------------------
// Each accepted word is one order event of a user. The event joins that
// user's ring of at most DEPTH entries, entries older than window_ms are
// expired from the front, and one result word gives the cancel and total
// counts left in the window, the alert and whether a full ring lost its
// oldest entry. The ring sequencer reads the user's ring state, appends the
// event (overwriting the oldest entry of a full ring), tests front entries
// for expiry (one entry memory read each) unless the ring was empty, and
// writes the state and result when the result register is free. A two-word
// queue lets events arrive while the sequencer works, and a result register
// lets the next event start while a result waits. After reset, a clearing
// pass zeroes each user's state, taking register writes but no events.
`default_nettype none

module windowed_cancel_ratio_detector_unit import wccr_pkg::*; #(
  parameter int USERS = USERS_DEF,
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wccr_in_if.sink    in_ch,
  wccr_out_if.source out_ch,
  wccr_cfg_if.sink   cfg_ch
);

  localparam int UW = (USERS > 1) ? $clog2(USERS) : 1;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        CFG_WINDOW:     cfg_nxt.window_ms     = cfg_ch.data[WINDOW_W-1:0];
        CFG_MIN_EVENTS: cfg_nxt.min_events    = cfg_ch.data[MINEV_W-1:0];
        CFG_RATIO:      cfg_nxt.ratio_percent = cfg_ch.data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{window_ms: WINDOW_RST, min_events: MINEV_RST, ratio_percent: RATIO_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  logic          q_valid;
  logic [UW-1:0] q_user;
  evt_t          q_evt;
  logic          q_pop;
  logic          clearing;

  wccr_front #(
    .USERS (USERS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_user   (q_user),
    .q_evt    (q_evt),
    .q_pop    (q_pop)
  );

  wccr_back #(
    .USERS (USERS),
    .DEPTH (DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_user   (q_user),
    .q_evt    (q_evt),
    .q_pop    (q_pop),
    .clearing (clearing),
    .cfg      (cfg_r),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/core/wccr_front.sv
// ----------------------------------------------------------------------------
// wccr_front
// Accepts events, maps the user index onto a ring and queues the word.
// ----------------------------------------------------------------------------
`default_nettype none

module wccr_front import wccr_pkg::*; #(
  parameter int USERS = USERS_DEF,
  localparam int UW   = (USERS > 1) ? $clog2(USERS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  wccr_in_if.sink            in_ch,
  input  wire logic          clearing,
  output logic               q_valid,
  output logic [UW-1:0]      q_user,
  output evt_t               q_evt,
  input  wire logic          q_pop
);

  localparam int IDX_CODES = 2 ** USER_IDX_W;

  logic [UW-1:0] mod_tab [IDX_CODES];

  for (genvar g = 0; g < IDX_CODES; g++) begin : g_mod
    assign mod_tab[g] = UW'(g % USERS);
  end

  logic [UW-1:0]      fifo_user [Q_DEPTH];
  evt_t               fifo_evt  [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push;

  assign in_ch.ready = (cnt_r != Q_CNT_W'(Q_DEPTH)) && !clearing;
  assign push        = in_ch.valid && in_ch.ready;

  assign q_valid = (cnt_r != '0);
  assign q_user  = fifo_user[rd_ptr_r];
  assign q_evt   = fifo_evt[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_user[wr_ptr_r] <= mod_tab[in_ch.user_index];
      fifo_evt[wr_ptr_r]  <= '{is_cancel: in_ch.is_cancel, event_time: in_ch.event_time};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/wccr_back.sv
// ----------------------------------------------------------------------------
// wccr_back
// Ring sequencer: appends the event, expires old entries, counts and alerts.
// ----------------------------------------------------------------------------
`default_nettype none

module wccr_back import wccr_pkg::*; #(
  parameter int USERS = USERS_DEF,
  parameter int DEPTH = DEPTH_DEF,
  localparam int UW   = (USERS > 1) ? $clog2(USERS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire logic [UW-1:0] q_user,
  input  wire evt_t          q_evt,
  output logic               q_pop,
  output logic               clearing,
  input  wire cfg_t          cfg,
  wccr_out_if.source         out_ch
);

  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int CELLS = USERS * DEPTH;
  localparam int AW    = $clog2(CELLS);
  localparam int UWORD = PW + 2 * CW;
  localparam int EWORD = TIME_W + 1;
  localparam int PRW   = CW + RATIO_W;
  localparam int MCW   = (CW > MINEV_W) ? CW : MINEV_W;

  function automatic logic [AW-1:0] slot_addr(logic [UW-1:0] u, logic [SW-1:0] pos);
    logic [SW-1:0] wrapped;
    wrapped = (pos >= SW'(DEPTH)) ? pos - SW'(DEPTH) : pos;
    return AW'(u) * AW'(DEPTH) + AW'(wrapped);
  endfunction

  function automatic logic [PW-1:0] head_inc(logic [PW-1:0] h);
    return (h == PW'(DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  // per-user ring state and ring entries
  logic [UWORD-1:0] usr_mem [USERS];
  logic [UWORD-1:0] usr_rd_r;
  logic             usr_we;
  logic [UW-1:0]    usr_wa, usr_ra;
  logic [UWORD-1:0] usr_wd;

  logic [EWORD-1:0] ent_mem [CELLS];
  logic [EWORD-1:0] ent_rd_r;
  logic             ent_we;
  logic [AW-1:0]    ent_wa, ent_ra;
  logic [EWORD-1:0] ent_wd;

  always_ff @(posedge clk) begin
    if (usr_we) begin
      usr_mem[usr_wa] <= usr_wd;
    end
    usr_rd_r <= usr_mem[usr_ra];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    ent_rd_r <= ent_mem[ent_ra];
  end

  back_state_t state_r, state_nxt;
  logic [UW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [UW-1:0]     user_r, user_nxt;
  logic              cancel_r, cancel_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     canc_r, canc_nxt;
  logic              over_r, over_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 alert_r, alert_nxt;
  logic [CNT_OUT_W-1:0] window_cancels_r, window_cancels_nxt;
  logic [CNT_OUT_W-1:0] total_count_r, total_count_nxt;
  logic                 overflowed_r, overflowed_nxt;

  logic [PW-1:0]     u_head;
  logic [CW-1:0]     u_fill, u_canc;
  logic              st_full, st_empty;
  logic [TIME_W-1:0] front_time;
  logic              front_cancel;
  logic              chk_drop, chk_last;
  logic              out_free, clr_last;
  logic [PRW-1:0]    prod_canc, prod_ratio;
  logic              alert_calc;

  assign {u_head, u_fill, u_canc} = usr_rd_r;
  assign st_full      = (u_fill == CW'(DEPTH));
  assign st_empty     = (u_fill == '0);
  assign front_time   = ent_rd_r[EWORD-1:1];
  assign front_cancel = ent_rd_r[0];
  assign chk_drop     = (fill_r != '0) && (time_r > front_time) &&
                        ((time_r - front_time) > TIME_W'(cfg.window_ms));
  assign chk_last     = (fill_r == CW'(1));
  assign out_free     = !out_valid_r || out_ch.ready;
  assign clr_last     = (clr_cnt_r == UW'(USERS - 1));
  assign prod_canc    = PRW'(canc_r) * PRW'(PCT_FULL);
  assign prod_ratio   = PRW'(cfg.ratio_percent) * PRW'(fill_r);
  assign alert_calc   = (MCW'(fill_r) >= MCW'(cfg.min_events)) && (prod_canc > prod_ratio);

  assign clearing = (state_r == S_CLEAR);
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (q_valid) state_nxt = S_STATE;
      S_STATE: begin
        priority if (st_full) state_nxt = S_FULL;
        else if (st_empty)    state_nxt = S_DONE;
        else                  state_nxt = S_CHECK;
      end
      S_FULL:  state_nxt = S_CHECK;
      S_CHECK: if (!chk_drop || chk_last) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    user_nxt    = user_r;
    cancel_nxt  = cancel_r;
    time_nxt    = time_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    canc_nxt    = canc_r;
    over_nxt    = over_r;

    usr_we = 1'b0;
    usr_wa = user_r;
    usr_wd = {head_r, fill_r, canc_r};
    usr_ra = user_r;
    ent_we = 1'b0;
    ent_wa = slot_addr(user_r, SW'(head_r));
    ent_wd = {time_r, cancel_r};
    ent_ra = slot_addr(user_r, SW'(head_r));

    out_valid_nxt      = out_valid_r && !out_ch.ready;
    alert_nxt          = alert_r;
    window_cancels_nxt = window_cancels_r;
    total_count_nxt    = total_count_r;
    overflowed_nxt     = overflowed_r;

    unique case (state_r)
      S_CLEAR: begin
        usr_we      = 1'b1;
        usr_wa      = clr_cnt_r;
        usr_wd      = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      S_IDLE: begin
        usr_ra = q_user;
        if (q_valid) begin
          user_nxt   = q_user;
          cancel_nxt = q_evt.is_cancel;
          time_nxt   = q_evt.event_time;
        end
      end
      S_STATE: begin
        head_nxt = u_head;
        over_nxt = 1'b0;
        ent_ra   = slot_addr(user_r, SW'(u_head));
        if (st_full) begin
          fill_nxt = u_fill;
          canc_nxt = u_canc;
        end else begin
          ent_we   = 1'b1;
          ent_wa   = slot_addr(user_r, SW'(u_head) + SW'(u_fill));
          fill_nxt = u_fill + 1'b1;
          canc_nxt = u_canc + CW'(cancel_r);
        end
      end
      S_FULL: begin
        // oldest entry goes, new one takes its slot
        ent_we   = 1'b1;
        ent_wa   = slot_addr(user_r, SW'(head_r));
        head_nxt = head_inc(head_r);
        ent_ra   = slot_addr(user_r, SW'(head_inc(head_r)));
        canc_nxt = canc_r - CW'(front_cancel && (canc_r != '0)) + CW'(cancel_r);
        over_nxt = 1'b1;
      end
      S_CHECK: begin
        if (chk_drop) begin
          head_nxt = head_inc(head_r);
          ent_ra   = slot_addr(user_r, SW'(head_inc(head_r)));
          fill_nxt = fill_r - 1'b1;
          canc_nxt = canc_r - CW'(front_cancel && (canc_r != '0));
        end
      end
      S_DONE: begin
        if (out_free) begin
          usr_we             = 1'b1;
          out_valid_nxt      = 1'b1;
          alert_nxt          = alert_calc;
          window_cancels_nxt = CNT_OUT_W'(canc_r);
          total_count_nxt    = CNT_OUT_W'(fill_r);
          overflowed_nxt     = over_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    user_r           <= user_nxt;
    cancel_r         <= cancel_nxt;
    time_r           <= time_nxt;
    head_r           <= head_nxt;
    fill_r           <= fill_nxt;
    canc_r           <= canc_nxt;
    over_r           <= over_nxt;
    alert_r          <= alert_nxt;
    window_cancels_r <= window_cancels_nxt;
    total_count_r    <= total_count_nxt;
    overflowed_r     <= overflowed_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.alert          = alert_r;
  assign out_ch.window_cancels = window_cancels_r;
  assign out_ch.total_count    = total_count_r;
  assign out_ch.overflowed     = overflowed_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> (fill_r != '0) && (fill_r <= CW'(DEPTH)))
    else $error("ring fill out of range at result");

  a_canc_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> canc_r <= fill_r)
    else $error("cancel count exceeds ring fill");

  a_clear_span: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_CLEAR && state_r == S_IDLE) |-> $past(clr_cnt_r) == UW'(USERS - 1))
    else $error("clearing pass ended early");

  a_full_over: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && $past(state_r) == S_FULL) |-> over_r && fill_r == CW'(DEPTH))
    else $error("full ring path lost overflow or fill");

endmodule

`default_nettype wire
